@@ hw/rtl/mlpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpt_pkg: shared types and constants
// Sizes, payload structs and small helpers for the page table walker.
// ----------------------------------------------------------------------------
package mlpt_pkg;

  localparam int OFFSET_BITS  = 4;
  localparam int TABLE_LEVELS = 3;
  localparam int FRAME_COUNT  = 64;
  localparam int WORD_BITS    = 32;

  localparam int PAGE_WORDS  = 1 << OFFSET_BITS;
  localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
  localparam int PADDR_BITS  = FRAME_BITS + OFFSET_BITS;
  localparam int PHYS_DEPTH  = FRAME_COUNT * PAGE_WORDS;
  localparam int PAGE_BITS   = OFFSET_BITS * TABLE_LEVELS;
  localparam int PAGE_COUNT  = 1 << PAGE_BITS;
  localparam int VIRT_BITS   = OFFSET_BITS * (TABLE_LEVELS + 1);
  localparam int SWAP_DEPTH  = 1 << VIRT_BITS;
  localparam int LVL_BITS    = $clog2(TABLE_LEVELS + 1);

  typedef struct packed {
    logic        func;
    logic [23:0] virt_addr;
    logic signed [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               success;
  } out_item_t;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // a stored word counts as a link only in 1..FRAME_COUNT-1
  function automatic logic is_link(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] fc;
    fc = WORD_BITS'(FRAME_COUNT);
    return (v != '0) && (v < fc);
  endfunction

  function automatic logic [PAGE_BITS-1:0] cyc_dist(input logic [PAGE_BITS-1:0] a,
                                                    input logic [PAGE_BITS-1:0] b);
    logic [PAGE_BITS-1:0] d;
    logic [PAGE_BITS-1:0] up;
    d  = (a > b) ? a - b : b - a;
    up = PAGE_BITS'(0) - d;
    if (d == '0) return '0;
    return (up < d) ? up : d;
  endfunction

endpackage

@@ hw/rtl/mlpt_ram.sv @@
// ----------------------------------------------------------------------------
// mlpt_ram: generic single port RAM
// One access per cycle, registered read data (the old word on a write).
// ----------------------------------------------------------------------------
module mlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/multilevel_page_table_with_paging.sv @@
// ----------------------------------------------------------------------------
// multilevel_page_table_with_paging: paged word memory with table walker
// Sequencer that walks, allocates, evicts and accesses one item at a time.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass zeroes physical memory
// (PHYS_DEPTH = 1024 words) and clears the swap-held bits in parallel
// (PAGE_COUNT = 4096 bits) before in_stall drops.
// A hit walk reads and checks one entry per level, then accesses the word
// and sends the result. A miss runs a depth-first free search of the table
// tree with an explicit stack; each entry is read on the single physical
// memory port, and each table popped takes a further step. A victim search
// walks the tree again, and a page move (evict, restore or clear) copies one
// word at a time through the same port. The one physical memory port is
// shared by the walk, the searches, the page moves and the access.
module multilevel_page_table_with_paging (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mlpt_pkg::out_item_t out_data
);
  import mlpt_pkg::*;

  typedef enum logic [18:0] {
    S_CLR   = 19'd1 << 0,
    S_IDLE  = 19'd1 << 1,
    S_WRD   = 19'd1 << 2,   // walk: read entry
    S_WCHK  = 19'd1 << 3,   // walk: check entry
    S_FSTRT = 19'd1 << 4,   // start free search
    S_FRD   = 19'd1 << 5,   // search: read entry
    S_FCHK  = 19'd1 << 6,   // search: look at entry
    S_FDEC  = 19'd1 << 7,   // search ended: choose rule
    S_VSTRT = 19'd1 << 8,
    S_MVRD  = 19'd1 << 9,   // page move: read word
    S_MVWR  = 19'd1 << 10,  // page move: write word
    S_UNLK  = 19'd1 << 11,  // clear parent entry
    S_LINK  = 19'd1 << 12,  // write link into current table
    S_FILL  = 19'd1 << 13,  // clear table or restore leaf
    S_FILW  = 19'd1 << 14,
    S_ARD   = 19'd1 << 15,  // access
    S_AWT   = 19'd1 << 16,
    S_OUT   = 19'd1 << 17,
    S_SWRD  = 19'd1 << 18   // held-bit read wait
  } state_t;

  localparam int DEPTH_BITS = $clog2(TABLE_LEVELS + 1);
  localparam int ST_DEPTH   = TABLE_LEVELS;

  state_t state_r, state_nxt;

  // item regs
  logic                   func_r;
  logic [VIRT_BITS-1:0]   va_r;
  logic [WORD_BITS-1:0]   wd_r;
  logic [WORD_BITS-1:0]   rd_r;
  logic                   succ_r;
  logic                   out_valid_r;
  // result of the item in progress, moved to the output regs in S_OUT
  logic [WORD_BITS-1:0]   res_rd_r;
  logic                   res_succ_r;

  // walk
  logic [LVL_BITS-1:0]    lvl_r;
  logic [FRAME_BITS-1:0]  cur_r;
  logic [FRAME_BITS-1:0]  nxt_frame_r;

  // search (one unit for both free and victim search)
  logic                   vmode_r;
  logic [DEPTH_BITS-1:0]  sdep_r;
  logic [FRAME_BITS-1:0]  snode_r [ST_DEPTH];
  logic [OFFSET_BITS:0]   scnt_r  [ST_DEPTH];   // next slot to look at
  logic                   sempty_r[ST_DEPTH];
  logic [PADDR_BITS-1:0]  spar_r  [ST_DEPTH];
  logic [PAGE_BITS-1:0]   spage_r [ST_DEPTH];
  logic [PAGE_BITS-1:0]   best_dist_r;
  logic [FRAME_BITS-1:0]  best_frame_r;
  logic [PAGE_BITS-1:0]   best_page_r;
  logic [PADDR_BITS-1:0]  best_par_r;
  logic [FRAME_BITS-1:0]  high_r;

  // page move
  logic [OFFSET_BITS:0]   wcnt_r;

  // clear
  logic [PAGE_BITS:0]     clr_r;

  // memories
  logic                   pm_we;
  logic [PADDR_BITS-1:0]  pm_addr;
  logic [WORD_BITS-1:0]   pm_wdata, pm_rdata;
  logic                   sw_we;
  logic [VIRT_BITS-1:0]   sw_addr;
  logic [WORD_BITS-1:0]   sw_wdata, sw_rdata;
  logic                   sh_we;
  logic [PAGE_BITS-1:0]   sh_addr;
  logic [0:0]             sh_wdata, sh_rdata;

  mlpt_ram #(.WIDTH(WORD_BITS), .DEPTH(PHYS_DEPTH)) u_phys (
    .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata));
  mlpt_ram #(.WIDTH(WORD_BITS), .DEPTH(SWAP_DEPTH)) u_swap (
    .clk(clk), .we(sw_we), .addr(sw_addr), .wdata(sw_wdata), .rdata(sw_rdata));
  mlpt_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_held (
    .clk(clk), .we(sh_we), .addr(sh_addr), .wdata(sh_wdata), .rdata(sh_rdata));

  // derived
  logic [PAGE_BITS-1:0]   page_w;
  logic [OFFSET_BITS-1:0] slot_w;
  logic                   in_range;
  logic [DEPTH_BITS-1:0]  top;
  logic [FRAME_BITS-1:0]  ent_frame;

  assign page_w   = va_r[VIRT_BITS-1:OFFSET_BITS];
  assign slot_w   = OFFSET_BITS'(va_r >> (OFFSET_BITS * (TABLE_LEVELS - int'(lvl_r))));
  assign in_range = (in_data.virt_addr >> VIRT_BITS) == '0;
  assign top      = sdep_r - DEPTH_BITS'(1);
  assign ent_frame = pm_rdata[FRAME_BITS-1:0];

  logic [$clog2(ST_DEPTH)-1:0] ti;
  assign ti = top[$clog2(ST_DEPTH)-1:0];

  // page number below a table node, extended by the slot taken
  function automatic logic [PAGE_BITS-1:0] child_page_slot(
      input logic [$clog2(ST_DEPTH)-1:0] i);
    return PAGE_BITS'({spage_r[i], scnt_r[i][OFFSET_BITS-1:0]});
  endfunction

  logic [PAGE_BITS-1:0] leaf_page;
  logic [PAGE_BITS-1:0] leaf_dist;
  assign leaf_page = child_page_slot(ti);
  assign leaf_dist = cyc_dist(page_w, leaf_page);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data.read_data = rd_r;
  assign out_data.success   = succ_r;

  // memory port control
  always_comb begin
    pm_we = 1'b0; pm_addr = '0; pm_wdata = '0;
    sw_we = 1'b0; sw_addr = '0; sw_wdata = pm_rdata;
    sh_we = 1'b0; sh_addr = page_w; sh_wdata = 1'b1;
    case (state_r)
      S_CLR: begin
        pm_we = (clr_r < (PAGE_BITS+1)'(PHYS_DEPTH));
        pm_addr = PADDR_BITS'(clr_r);
        sh_we = 1'b1; sh_addr = PAGE_BITS'(clr_r); sh_wdata = 1'b0;
      end
      S_WRD:  pm_addr = {cur_r, slot_w};
      S_FRD:  pm_addr = {snode_r[ti], scnt_r[ti][OFFSET_BITS-1:0]};
      S_MVRD: pm_addr = {best_frame_r, wcnt_r[OFFSET_BITS-1:0]};
      S_MVWR: begin
        sw_we = 1'b1; sw_addr = {best_page_r, wcnt_r[OFFSET_BITS-1:0]};
        sh_we = 1'b1; sh_addr = best_page_r;
      end
      S_UNLK: begin pm_we = 1'b1; pm_addr = best_par_r; end
      S_LINK: begin
        pm_we = 1'b1; pm_addr = {cur_r, slot_w};
        pm_wdata = WORD_BITS'(nxt_frame_r);
      end
      S_FILL: sw_addr = {page_w, wcnt_r[OFFSET_BITS-1:0]};
      S_FILW: begin
        pm_we = 1'b1; pm_addr = {nxt_frame_r, wcnt_r[OFFSET_BITS-1:0]};
        pm_wdata = (int'(lvl_r) == TABLE_LEVELS-1) ? sw_rdata : '0;
      end
      S_ARD: begin
        pm_addr = {cur_r, va_r[OFFSET_BITS-1:0]};
        pm_we = func_r; pm_wdata = wd_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (PAGE_BITS+1)'(PAGE_COUNT-1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          func_r <= in_data.func;
          va_r   <= VIRT_BITS'(in_data.virt_addr);
          wd_r   <= WORD_BITS'(in_data.write_data);
          lvl_r  <= '0;
          cur_r  <= '0;
          if (in_range) state_r <= S_WRD;
          else begin
            res_rd_r <= '0; res_succ_r <= 1'b0; state_r <= S_OUT;
          end
        end
        S_WRD: state_r <= S_WCHK;
        S_WCHK: begin
          if (is_link(pm_rdata)) begin
            cur_r <= ent_frame;
            lvl_r <= lvl_r + 1'b1;
            state_r <= (int'(lvl_r) == TABLE_LEVELS-1) ? S_ARD : S_WRD;
          end else state_r <= S_FSTRT;
        end
        S_FSTRT, S_VSTRT: begin
          vmode_r <= (state_r == S_VSTRT);
          sdep_r <= DEPTH_BITS'(1);
          snode_r[0] <= '0; scnt_r[0] <= '0; sempty_r[0] <= 1'b1;
          spar_r[0] <= '0; spage_r[0] <= '0;
          best_frame_r <= '0; best_par_r <= '0; best_page_r <= '0;
          best_dist_r <= '0;
          if (state_r == S_FSTRT) high_r <= '0;
          state_r <= S_FRD;
        end
        S_FRD: begin
          if (scnt_r[ti] == (OFFSET_BITS+1)'(PAGE_WORDS)) begin
            // node done: pop
            if (!vmode_r && sempty_r[ti] && snode_r[ti] != cur_r) begin
              best_frame_r <= snode_r[ti];
              best_par_r <= spar_r[ti];
            end
            sdep_r <= top;
            if (top == '0) state_r <= S_FDEC;
          end else state_r <= S_FCHK;
        end
        S_FCHK: begin
          scnt_r[ti] <= scnt_r[ti] + 1'b1;
          state_r <= S_FRD;
          if (is_link(pm_rdata)) begin
            sempty_r[ti] <= 1'b0;
            if (ent_frame > high_r) high_r <= ent_frame;
            if (int'(sdep_r) < TABLE_LEVELS) begin
              snode_r[sdep_r[$clog2(ST_DEPTH)-1:0]] <= ent_frame;
              scnt_r[sdep_r[$clog2(ST_DEPTH)-1:0]] <= '0;
              sempty_r[sdep_r[$clog2(ST_DEPTH)-1:0]] <= 1'b1;
              spar_r[sdep_r[$clog2(ST_DEPTH)-1:0]] <=
                {snode_r[ti], scnt_r[ti][OFFSET_BITS-1:0]};
              spage_r[sdep_r[$clog2(ST_DEPTH)-1:0]] <= child_page_slot(ti);
              sdep_r <= sdep_r + 1'b1;
            end else if (vmode_r) begin
              // leaf page reached from last table level
              if (leaf_dist > best_dist_r) begin
                best_dist_r <= leaf_dist;
                best_frame_r <= ent_frame;
                best_page_r <= leaf_page;
                best_par_r <= {snode_r[ti], scnt_r[ti][OFFSET_BITS-1:0]};
              end
            end
          end
        end
        S_FDEC: begin
          if (!vmode_r) begin
            if (best_frame_r != '0) begin
              nxt_frame_r <= best_frame_r; state_r <= S_UNLK;
            end else if (int'(high_r) + 1 < FRAME_COUNT) begin
              nxt_frame_r <= high_r + 1'b1; state_r <= S_LINK;
            end else state_r <= S_VSTRT;
          end else begin
            nxt_frame_r <= best_frame_r; wcnt_r <= '0; state_r <= S_MVRD;
          end
        end
        S_MVRD: state_r <= S_MVWR;
        S_MVWR: begin
          wcnt_r <= wcnt_r + 1'b1;
          state_r <= (wcnt_r == (OFFSET_BITS+1)'(PAGE_WORDS-1)) ? S_UNLK : S_MVRD;
        end
        S_UNLK: state_r <= S_LINK;
        S_LINK: begin
          wcnt_r <= '0;
          state_r <= S_SWRD;
        end
        S_SWRD: begin
          // held bit for the wanted page is now on sh_rdata
          if (int'(lvl_r) == TABLE_LEVELS-1 && !sh_rdata[0]) begin
            cur_r <= nxt_frame_r; lvl_r <= lvl_r + 1'b1; state_r <= S_ARD;
          end else state_r <= S_FILL;
        end
        S_FILL: state_r <= S_FILW;
        S_FILW: begin
          wcnt_r <= wcnt_r + 1'b1;
          if (wcnt_r == (OFFSET_BITS+1)'(PAGE_WORDS-1)) begin
            cur_r <= nxt_frame_r;
            lvl_r <= lvl_r + 1'b1;
            state_r <= (int'(lvl_r) == TABLE_LEVELS-1) ? S_ARD : S_WRD;
          end else state_r <= S_FILL;
        end
        S_ARD: state_r <= S_AWT;
        S_AWT: begin
          res_rd_r <= (func_r == FUNC_READ) ? pm_rdata : '0;
          res_succ_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || !out_stall) begin
          out_valid_r <= 1'b1;
          rd_r <= res_rd_r;
          succ_r <= res_succ_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result is held stable in the output register while the output stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && in_valid |=> in_stall)
    else $error("accepted item without going busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> nxt_frame_r != '0)
    else $error("linking the root frame");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |-> out_data.read_data == '0)
    else $error("failed item carries data");
endmodule
